[rtl/tmhs_pkg.sv]
package tmhs_pkg;

   localparam int HEAP_DEPTH_DEF  = 64;
   localparam int OWNER_COUNT_DEF = 256;

   localparam int KIND_W     = 2;
   localparam int OWNER_W    = 8;
   localparam int DEADLINE_W = 48;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 7;

   localparam logic [KIND_W-1:0] KIND_ARM    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_POLL   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NONE      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_ARMED = 3'd4;

   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [OWNER_W-1:0]    owner;
      logic [DEADLINE_W-1:0] deadline;
      logic [DEADLINE_W-1:0] now_time;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [OWNER_W-1:0]    expired_owner;
      logic [DEADLINE_W-1:0] expired_deadline;
      logic [COUNT_W-1:0]    pending_count;
   } rsp_type;

endpackage

[rtl/tmhs_if.sv]
interface tmhs_req_if;
   logic                valid;
   logic                ready;
   tmhs_pkg::req_type   payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface tmhs_rsp_if;
   logic                valid;
   logic                ready;
   tmhs_pkg::rsp_type   payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/tmhs_pos_table.sv]
// Owner position table: memory plus clearing sweep after reset.
module tmhs_pos_table #(
   parameter int OWNER_COUNT = tmhs_pkg::OWNER_COUNT_DEF,
   parameter int POS_W       = 7,
   parameter int OWN_IDX_W   = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [OWN_IDX_W-1:0] wr_addr,
   input  logic [POS_W-1:0]     wr_data,
   input  logic [OWN_IDX_W-1:0] rd_addr,
   output logic [POS_W-1:0]     rd_data,
   input  logic [POS_W-1:0]     clear_value,
   output logic                 clearing
);
   logic [POS_W-1:0]   mem [OWNER_COUNT];
   logic [OWN_IDX_W:0] clr_ff, clr_in;
   logic               clearing_ff, clearing_in;

   always_comb begin
      clr_in      = clr_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == (OWN_IDX_W+1)'(OWNER_COUNT - 1)) clearing_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         clearing_ff <= 1'b1;
      end else begin
         clr_ff      <= clr_in;
         clearing_ff <= clearing_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) mem[clr_ff[OWN_IDX_W-1:0]] <= clear_value;
      else if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end

   assign clearing = clearing_ff;
endmodule

[rtl/timeout_min_heap_scheduler_top.sv]
// Channel | Dir | Fields                                          | Transfer
// req_if  | in  | kind, owner, deadline, now_time                 | valid & ready
// rsp_if  | out | status, expired_owner, expired_deadline, pending | valid & ready
//
// One request at a time. A sequencer walks the heap with deadline comparators
// and the heap memory's single registered read port, which sets the pace of
// sift-up and sift-down. An unknown kind goes straight to the response; a
// re-arm of the root removes it, sifts the last entry down, then inserts and
// sifts up the new entry. After reset, the owner table is swept over all
// OWNER_COUNT entries; no request is taken meanwhile. req_if is held off while
// a response waits, so a stalled rsp_if side holds the block until the
// transfer completes.
module timeout_min_heap_scheduler_top #(
   parameter int HEAP_DEPTH  = tmhs_pkg::HEAP_DEPTH_DEF,
   parameter int OWNER_COUNT = tmhs_pkg::OWNER_COUNT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   tmhs_req_if.sink   req_if,
   tmhs_rsp_if.source rsp_if
);
   localparam int IDX_W = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
   localparam int POS_W = $clog2(HEAP_DEPTH + 1);   // holds "not armed" value
   localparam int OWN_IDX_W = (OWNER_COUNT > 1) ? $clog2(OWNER_COUNT) : 1;
   localparam int DW = tmhs_pkg::DEADLINE_W;
   localparam int OW = tmhs_pkg::OWNER_W;
   localparam logic [POS_W-1:0] NOT_ARMED = POS_W'(HEAP_DEPTH);

   typedef struct packed {
      logic [DW-1:0] deadline;
      logic [OW-1:0] owner;
   } entry_type;

   typedef enum logic [4:0] {
      S_IDLE, S_LOOK, S_LOOK_W, S_CHECK, S_POLL_R, S_POLL_W, S_POLL_C,
      S_RM_LAST, S_RM_LAST_W, S_RM_PUT,
      S_INS,
      S_UP_RD, S_UP_W, S_UP_CMP,
      S_DN_L, S_DN_LW, S_DN_R, S_DN_RW, S_DN_CMP,
      S_OUT
   } state_type;

   state_type state_ff;

   // heap memory: one write, one registered read port
   entry_type heap_mem [HEAP_DEPTH];
   logic            hw_en;
   logic [IDX_W-1:0] hw_addr, hr_addr;
   entry_type       hw_data, hr_data;
   always_ff @(posedge clock) begin
      if (hw_en) heap_mem[hw_addr] <= hw_data;
      hr_data <= heap_mem[hr_addr];
   end

   // position table
   logic                 pw_en, clearing;
   logic [OWN_IDX_W-1:0] pw_addr, pr_addr;
   logic [POS_W-1:0]     pw_data, pr_data;
   tmhs_pos_table #(.OWNER_COUNT(OWNER_COUNT), .POS_W(POS_W),
                    .OWN_IDX_W(OWN_IDX_W)) u_pos (
      .clock, .reset, .wr_en(pw_en), .wr_addr(pw_addr), .wr_data(pw_data),
      .rd_addr(pr_addr), .rd_data(pr_data), .clear_value(NOT_ARMED),
      .clearing(clearing));

   tmhs_pkg::req_type        req_ff;
   logic [POS_W-1:0]         count_ff;
   logic [IDX_W-1:0]         pos_ff, oth_ff, best_ff;
   entry_type                cur_ff, oth_e_ff, best_e_ff;
   entry_type                req_e;
   logic                     rm_arm_ff;   // removal is part of a re-arm
   logic                     owner_ok;
   logic                     up_swap, dn_swap;
   logic [POS_W-1:0]         left_w, right_w;
   logic [POS_W:0]           left_x;
   tmhs_pkg::rsp_type        rsp_ff;
   logic                     rsp_valid_ff;

   // position table write from one helper per cycle
   logic                 pwr_en;
   logic [OW-1:0]        pwr_owner;
   logic [POS_W-1:0]     pwr_pos;
   // second write of a swap is done in a later cycle: hold it here
   logic                 pend_ff;
   entry_type            pend_e_ff;
   logic [IDX_W-1:0]     pend_pos_ff;

   assign owner_ok = (int'(req_ff.owner) < OWNER_COUNT);
   assign req_e    = {req_ff.deadline, req_ff.owner};
   assign left_x   = (POS_W+1)'({pos_ff, 1'b1});
   assign left_w   = POS_W'({pos_ff, 1'b1});
   assign right_w  = left_w + 1'b1;
   assign up_swap  = (oth_e_ff.deadline > cur_ff.deadline);
   assign dn_swap  = (best_ff != pos_ff);

   assign req_if.ready   = (state_ff == S_IDLE) && !clearing && !rsp_valid_ff;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   always_comb begin
      hw_en = 1'b0; hw_addr = pos_ff; hw_data = cur_ff;
      hr_addr = pos_ff;
      pwr_en = 1'b0; pwr_owner = cur_ff.owner; pwr_pos = POS_W'(pos_ff);
      pr_addr = OWN_IDX_W'(req_ff.owner);
      case (state_ff)
         S_LOOK:      hr_addr = IDX_W'(0);
         S_LOOK_W:    hr_addr = pr_data[IDX_W-1:0];
         S_POLL_R:    hr_addr = IDX_W'(0);
         S_RM_LAST:   hr_addr = IDX_W'(count_ff);
         S_UP_RD:     hr_addr = IDX_W'((pos_ff - 1'b1) >> 1);
         S_DN_L:      hr_addr = left_w[IDX_W-1:0];
         S_DN_R:      hr_addr = right_w[IDX_W-1:0];
         default:     hr_addr = pos_ff;
      endcase
      if (pend_ff) begin
         hw_en = 1'b1; hw_addr = pend_pos_ff; hw_data = pend_e_ff;
         pwr_en = 1'b1; pwr_owner = pend_e_ff.owner; pwr_pos = POS_W'(pend_pos_ff);
      end else if (state_ff == S_RM_PUT || state_ff == S_INS) begin
         hw_en = 1'b1; hw_addr = pos_ff; hw_data = cur_ff;
         pwr_en = 1'b1; pwr_owner = cur_ff.owner; pwr_pos = POS_W'(pos_ff);
      end else if (state_ff == S_UP_CMP && up_swap) begin
         // parent moves down into pos
         hw_en = 1'b1; hw_addr = pos_ff; hw_data = oth_e_ff;
         pwr_en = 1'b1; pwr_owner = oth_e_ff.owner; pwr_pos = POS_W'(pos_ff);
      end else if (state_ff == S_DN_CMP && dn_swap) begin
         // cur moves down into the chosen child
         hw_en = 1'b1; hw_addr = best_ff; hw_data = cur_ff;
         pwr_en = 1'b1; pwr_owner = cur_ff.owner; pwr_pos = POS_W'(best_ff);
      end else if (state_ff == S_CHECK) begin
         pwr_en = 1'b1; pwr_owner = req_ff.owner; pwr_pos = NOT_ARMED;
      end else if (state_ff == S_POLL_C) begin
         pwr_en = 1'b1; pwr_owner = cur_ff.owner; pwr_pos = NOT_ARMED;
      end
      pw_en   = pwr_en && (int'(pwr_owner) < OWNER_COUNT);
      pw_addr = OWN_IDX_W'(pwr_owner);
      pw_data = pwr_pos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         rm_arm_ff    <= 1'b0;
      end else begin
         pend_ff <= (state_ff == S_UP_CMP && up_swap) || (state_ff == S_DN_CMP && dn_swap);
         if (rsp_valid_ff && rsp_if.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (req_if.valid && req_if.ready) begin
               req_ff <= req_if.payload;
               rsp_ff <= {tmhs_pkg::ST_DONE, OW'(0), DW'(0), tmhs_pkg::COUNT_W'(0)};
               rm_arm_ff <= 1'b0;
               case (req_if.payload.kind)
                  tmhs_pkg::KIND_ARM, tmhs_pkg::KIND_CANCEL: state_ff <= S_LOOK;
                  tmhs_pkg::KIND_POLL: state_ff <= S_POLL_R;
                  default: state_ff <= S_OUT;
               endcase
            end
            S_LOOK: state_ff <= S_LOOK_W;      // position table read
            S_LOOK_W: begin                    // heap read at that position
               if (!owner_ok || pr_data >= count_ff) begin
                  // not armed
                  if (req_ff.kind == tmhs_pkg::KIND_ARM && owner_ok) begin
                     if (count_ff >= POS_W'(HEAP_DEPTH)) begin
                        rsp_ff.status <= tmhs_pkg::ST_FULL;
                        state_ff <= S_OUT;
                     end else state_ff <= S_INS;
                  end else begin
                     rsp_ff.status <= tmhs_pkg::ST_NOT_ARMED;
                     state_ff <= S_OUT;
                  end
                  cur_ff <= req_e;
                  pos_ff <= IDX_W'(count_ff);
               end else begin
                  pos_ff   <= pr_data[IDX_W-1:0];
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               // hr_data is entry at pos; a stale table entry reads as not armed
               if (hr_data.owner != req_ff.owner) begin
                  if (req_ff.kind == tmhs_pkg::KIND_ARM) begin
                     if (count_ff >= POS_W'(HEAP_DEPTH)) begin
                        rsp_ff.status <= tmhs_pkg::ST_FULL;
                        state_ff <= S_OUT;
                     end else begin
                        cur_ff   <= req_e;
                        pos_ff   <= IDX_W'(count_ff);
                        state_ff <= S_INS;
                     end
                  end else begin
                     rsp_ff.status <= tmhs_pkg::ST_NOT_ARMED;
                     state_ff <= S_OUT;
                  end
               end else begin
                  rm_arm_ff <= (req_ff.kind == tmhs_pkg::KIND_ARM);
                  count_ff  <= count_ff - 1'b1;
                  state_ff  <= S_RM_LAST;
               end
            end
            S_POLL_R: state_ff <= S_POLL_W;
            S_POLL_W: begin
               if (count_ff != '0 && hr_data.deadline <= req_ff.now_time) begin
                  rsp_ff   <= {tmhs_pkg::ST_EXPIRED, hr_data.owner, hr_data.deadline,
                               rsp_ff.pending_count};
                  cur_ff   <= hr_data;
                  pos_ff   <= '0;
                  count_ff <= count_ff - 1'b1;
                  state_ff <= S_POLL_C;
               end else begin
                  rsp_ff.status <= tmhs_pkg::ST_NONE;
                  state_ff <= S_OUT;
               end
            end
            S_POLL_C: state_ff <= S_RM_LAST;   // NOT_ARMED written for popped owner
            S_RM_LAST: begin
               // count already decremented; last entry index = count
               if (POS_W'(pos_ff) == count_ff) begin
                  if (rm_arm_ff) begin
                     cur_ff   <= req_e;
                     pos_ff   <= IDX_W'(count_ff);
                     state_ff <= S_INS;
                  end else state_ff <= S_OUT;
               end else state_ff <= S_RM_LAST_W;
            end
            S_RM_LAST_W: begin
               cur_ff   <= hr_data;
               state_ff <= S_RM_PUT;
            end
            S_RM_PUT: state_ff <= S_UP_RD;     // last entry written into hole
            S_INS: begin
               count_ff <= count_ff + 1'b1;
               rm_arm_ff <= 1'b0;
               state_ff <= S_UP_RD;
            end
            S_UP_RD: begin
               oth_ff <= IDX_W'((pos_ff - 1'b1) >> 1);
               if (pos_ff == '0) state_ff <= S_DN_L;
               else state_ff <= S_UP_W;
            end
            S_UP_W: begin
               oth_e_ff <= hr_data;
               state_ff <= S_UP_CMP;
            end
            S_UP_CMP: begin
               if (up_swap) begin
                  // parent moves down to pos now, cur goes to parent next cycle
                  pend_e_ff   <= cur_ff;
                  pend_pos_ff <= oth_ff;
                  pos_ff      <= oth_ff;
                  state_ff    <= S_UP_RD;
               end else state_ff <= S_DN_L;
            end
            S_DN_L: begin
               best_ff   <= pos_ff;
               best_e_ff <= cur_ff;
               if (left_x >= (POS_W+1)'(count_ff)) begin
                  if (rm_arm_ff) begin
                     cur_ff   <= req_e;
                     pos_ff   <= IDX_W'(count_ff);
                     state_ff <= S_INS;
                  end else state_ff <= S_OUT;
               end else state_ff <= S_DN_LW;
            end
            S_DN_LW: begin
               if (hr_data.deadline < best_e_ff.deadline) begin
                  best_ff   <= left_w[IDX_W-1:0];
                  best_e_ff <= hr_data;
               end
               state_ff <= (right_w < count_ff) ? S_DN_R : S_DN_CMP;
            end
            S_DN_R: state_ff <= S_DN_RW;
            S_DN_RW: begin
               if (hr_data.deadline < best_e_ff.deadline) begin
                  best_ff   <= right_w[IDX_W-1:0];
                  best_e_ff <= hr_data;
               end
               state_ff <= S_DN_CMP;
            end
            S_DN_CMP: begin
               if (!dn_swap) begin
                  if (rm_arm_ff) begin
                     cur_ff   <= req_e;
                     pos_ff   <= IDX_W'(count_ff);
                     state_ff <= S_INS;
                  end else state_ff <= S_OUT;
               end else begin
                  // cur goes to child now, child moves up to pos next cycle
                  pend_e_ff   <= best_e_ff;
                  pend_pos_ff <= pos_ff;
                  pos_ff      <= best_ff;
                  state_ff    <= S_DN_L;
               end
            end
            S_OUT: if (!rsp_valid_ff) begin
               rsp_ff.pending_count <= tmhs_pkg::COUNT_W'(count_ff);
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

   localparam int DEPTH      = tmhs_pkg::HEAP_DEPTH_DEF;
   localparam int OWNERS     = tmhs_pkg::OWNER_COUNT_DEF;
   localparam int N_RANDOM   = 1450;
   localparam int CYCLE_CAP  = 600000;
   localparam logic [tmhs_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

   // One heap slot in the testbench's own shadow of the timer queue.
   typedef struct {
      logic [tmhs_pkg::DEADLINE_W-1:0] deadline;
      logic [tmhs_pkg::OWNER_W-1:0]    owner;
   } slot_type;

   // Shadow timer queue plus the queue of results it predicts.
   class scoreboard_type;
      slot_type            heap[DEPTH];
      int                  where[OWNERS];
      int                  count;
      tmhs_pkg::rsp_type   pending_rsp[$];
      int                  errors;

      function void clear();
         count = 0;
         errors = 0;
         foreach (where[i]) where[i] = DEPTH;
      endfunction

      function void place(int pos, slot_type e);
         heap[pos] = e;
         where[e.owner] = pos;
      endfunction

      function void exchange(int a, int b);
         slot_type ta;
         slot_type tb;
         ta = heap[a];
         tb = heap[b];
         place(a, tb);
         place(b, ta);
      endfunction

      function int rise(int pos);
         int up;
         while (pos > 0) begin
            up = (pos - 1) >> 1;
            if (heap[up].deadline <= heap[pos].deadline) break;
            exchange(pos, up);
            pos = up;
         end
         return pos;
      endfunction

      function void sink(int pos);
         int l;
         int best;
         forever begin
            l = 2 * pos + 1;
            best = pos;
            if (l < count && heap[l].deadline < heap[best].deadline) best = l;
            if (l + 1 < count && heap[l + 1].deadline < heap[best].deadline)
               best = l + 1;
            if (best == pos) return;
            exchange(pos, best);
            pos = best;
         end
      endfunction

      function void drop(int pos);
         where[heap[pos].owner] = DEPTH;
         count--;
         if (pos != count) begin
            place(pos, heap[count]);
            sink(rise(pos));
         end
      endfunction

      function int find(logic [tmhs_pkg::OWNER_W-1:0] o);
         int p;
         p = where[o];
         if (p >= count || heap[p].owner != o) return DEPTH;
         return p;
      endfunction

      // Apply one accepted request and queue the expected response.
      function void note_request(tmhs_pkg::req_type r);
         tmhs_pkg::rsp_type x;
         slot_type          e;
         int                p;
         x = '0;
         x.status = tmhs_pkg::ST_DONE;
         case (r.kind)
            tmhs_pkg::KIND_ARM: begin
               p = find(r.owner);
               if (p == DEPTH && count >= DEPTH) begin
                  x.status = tmhs_pkg::ST_FULL;
               end else begin
                  if (p != DEPTH) drop(p);
                  e.deadline = r.deadline;
                  e.owner = r.owner;
                  place(count, e);
                  count++;
                  void'(rise(count - 1));
               end
            end
            tmhs_pkg::KIND_CANCEL: begin
               p = find(r.owner);
               if (p == DEPTH) x.status = tmhs_pkg::ST_NOT_ARMED;
               else drop(p);
            end
            tmhs_pkg::KIND_POLL: begin
               if (count > 0 && heap[0].deadline <= r.now_time) begin
                  x.status = tmhs_pkg::ST_EXPIRED;
                  x.expired_owner = heap[0].owner;
                  x.expired_deadline = heap[0].deadline;
                  drop(0);
               end else begin
                  x.status = tmhs_pkg::ST_NONE;
               end
            end
            default: ;
         endcase
         x.pending_count = count[tmhs_pkg::COUNT_W-1:0];
         pending_rsp.push_back(x);
      endfunction

      function void check_response(tmhs_pkg::rsp_type got);
         tmhs_pkg::rsp_type want;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response %h", $time, got);
            errors++;
            return;
         end
         want = pending_rsp.pop_front();
         if (got.status !== want.status) begin
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
            errors++;
         end
         if (got.expired_owner !== want.expired_owner) begin
            $display("%0t: expired_owner exp %0d got %0d", $time,
                     want.expired_owner, got.expired_owner);
            errors++;
         end
         if (got.expired_deadline !== want.expired_deadline) begin
            $display("%0t: expired_deadline exp %0h got %0h", $time,
                     want.expired_deadline, got.expired_deadline);
            errors++;
         end
         if (got.pending_count !== want.pending_count) begin
            $display("%0t: pending_count exp %0d got %0d", $time,
                     want.pending_count, got.pending_count);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   tmhs_req_if req_if ();
   tmhs_rsp_if rsp_if ();

   timeout_min_heap_scheduler_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   scoreboard_type sb;
   bit  calm;        // last part of the run: no idling on either side
   bit  hold_rsp;    // long receiver hold-off, to back up the request side
   int  cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      sb = new();
      sb.clear();
   end

   // Cycle counter doubles as the watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("timeout_min_heap_scheduler_top regression: fail");
         $finish;
      end
   end

   // Note every request transfer and check every response transfer at the edge.
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) sb.note_request(req_if.payload);
      if (!reset && rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.payload);
   end

   // Receiver: random stall bursts, plus the long hold-off when asked.
   initial begin : rsp_side
      int gap;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
            @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Hold the receiver off for a long stretch, counted here.
   task automatic hold_off(int n);
      hold_rsp = 1'b1;
      repeat (n) @(posedge clock);
      hold_rsp = 1'b0;
   endtask

   // Offer one request; wait for its transfer. Valid stays high across
   // back-to-back items, only dropped for an idle burst.
   task automatic send(tmhs_pkg::req_type r);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= r;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   function automatic logic [tmhs_pkg::DEADLINE_W-1:0] rand_time();
      logic [tmhs_pkg::DEADLINE_W-1:0] t;
      case ($urandom_range(0, 5))
         0: t = '0;
         1: t = '1;
         2: t = tmhs_pkg::DEADLINE_W'({$urandom(), $urandom()});
         default: t = tmhs_pkg::DEADLINE_W'($urandom_range(0, 2000));  // ties, expiries
      endcase
      return t;
   endfunction

   function automatic tmhs_pkg::req_type mk(logic [tmhs_pkg::KIND_W-1:0] k, int o,
                                            logic [tmhs_pkg::DEADLINE_W-1:0] d,
                                            logic [tmhs_pkg::DEADLINE_W-1:0] n);
      tmhs_pkg::req_type r;
      r.kind = k;
      r.owner = tmhs_pkg::OWNER_W'(o);
      r.deadline = d;
      r.now_time = n;
      return r;
   endfunction

   // Owner pool: mostly a small set so re-arm and cancel hit live timers.
   function automatic int pick_owner(int span);
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, OWNERS - 1);
      return $urandom_range(0, span - 1);
   endfunction

   initial begin : stimulus
      tmhs_pkg::req_type r;
      int k;
      int span;
      reset = 1'b1;
      calm = 1'b0;
      hold_rsp = 1'b0;
      req_if.valid <= 1'b0;
      req_if.payload <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty poll, idle cancel, extremes, ties, re-arm, unknown kind.
      send(mk(tmhs_pkg::KIND_POLL, 0, '0, '1));
      send(mk(tmhs_pkg::KIND_CANCEL, 255, '0, '0));
      send(mk(tmhs_pkg::KIND_ARM, 255, '1, '0));
      send(mk(tmhs_pkg::KIND_ARM, 0, '0, '0));
      send(mk(tmhs_pkg::KIND_ARM, 7, 48'd100, '0));
      send(mk(tmhs_pkg::KIND_ARM, 8, 48'd100, '0));        // equal deadlines
      send(mk(tmhs_pkg::KIND_ARM, 9, 48'd100, '0));
      send(mk(tmhs_pkg::KIND_ARM, 7, 48'd5, '0));          // re-arm moves timer up
      send(mk(KIND_UNUSED, 'hAA, '1, '1));
      send(mk(tmhs_pkg::KIND_POLL, 0, '0, '0));            // zero deadline expires at zero
      send(mk(tmhs_pkg::KIND_POLL, 0, '0, 48'd4));         // not yet
      send(mk(tmhs_pkg::KIND_POLL, 0, '0, 48'd100));
      send(mk(tmhs_pkg::KIND_CANCEL, 8, '0, '0));          // cancel from the middle
      send(mk(tmhs_pkg::KIND_CANCEL, 8, '0, '0));
      send(mk(tmhs_pkg::KIND_POLL, 0, '0, '1));
      send(mk(tmhs_pkg::KIND_POLL, 0, '0, '1));
      send(mk(tmhs_pkg::KIND_POLL, 0, '0, '1));
      send(mk(tmhs_pkg::KIND_POLL, 0, '0, '1));

      // Fill to capacity with the receiver held off, so the block stalls input.
      fork
         hold_off(400);
         for (int i = 0; i < DEPTH; i++)
            send(mk(tmhs_pkg::KIND_ARM, 2 * i + 1,
                    tmhs_pkg::DEADLINE_W'({$urandom(), $urandom()}), '0));
      join
      send(mk(tmhs_pkg::KIND_ARM, 200, 48'd1, '0));        // full
      send(mk(tmhs_pkg::KIND_ARM, 1, '0, '0));             // re-arm while full
      send(mk(tmhs_pkg::KIND_CANCEL, 254, '0, '0));
      for (int i = 0; i < DEPTH; i++) send(mk(tmhs_pkg::KIND_POLL, 0, '0, '1));

      // Random: phases with different owner spans to vary fill level.
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM - 300) calm = 1'b1;
         span = (n / 400) % 2 == 0 ? 96 : 40;
         k = $urandom_range(0, 19);
         if (k < 9)
            r = mk(tmhs_pkg::KIND_ARM, pick_owner(span), rand_time(), '0);
         else if (k < 13)
            r = mk(tmhs_pkg::KIND_CANCEL, pick_owner(span), rand_time(), '0);
         else if (k < 19)
            r = mk(tmhs_pkg::KIND_POLL, $urandom_range(0, 255), rand_time(), rand_time());
         else
            r = mk(KIND_UNUSED, $urandom_range(0, 255), rand_time(), rand_time());
         send(r);
      end
      req_if.valid <= 1'b0;

      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.pending_rsp.size() == 0)
         $display("timeout_min_heap_scheduler_top regression: pass");
      else
         $display("timeout_min_heap_scheduler_top regression: fail");
      $finish;
   end
endmodule
